FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst, a, c, msg)
`define ASSERT_NEXT(lbl, clk, rst, a, c, msg)
`endif
`endif

FILE: rtl/dcl_pkg.sv
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared types and constants of the interval constraint solver.
// ----------------------------------------------------------------------------
package dcl_pkg;
   localparam int FIELD_W  = 11;
   localparam int VAL_W    = 12;
   localparam int STATUS_W = 2;
   localparam int PASS_W   = 12;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INFEASIBLE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD        = 2'd2;

   localparam logic [FIELD_W-1:0] NODE_COUNT_RESET = 11'd1024;

   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type range_start;
      field_type range_end;
      field_type min_count;
   } rule_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_STORE,
      OP_RD_RULE,
      OP_CLEAR,
      OP_CARRY0,
      OP_RD_NODE,
      OP_FWD,
      OP_BWD,
      OP_LAT_RULE,
      OP_LAT_SRC,
      OP_CSTR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic bad_range;
      logic raise;
      logic over_n;
   } stat_type;
endpackage

FILE: rtl/dcl_if.sv
// ----------------------------------------------------------------------------
// dcl channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface dcl_req_if import dcl_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type range_start;
   field_type range_end;
   field_type min_count;
   logic      last;
   modport source (output valid, range_start, range_end, min_count, last, input ready);
   modport sink (input valid, range_start, range_end, min_count, last, output ready);
endinterface

interface dcl_rsp_if import dcl_pkg::*; ();
   logic                valid;
   logic                ready;
   field_type           minimum_total;
   logic [STATUS_W-1:0] status;
   modport source (output valid, minimum_total, status, input ready);
   modport sink (input valid, minimum_total, status, output ready);
endinterface

interface dcl_csr_if import dcl_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type node_count;
   modport source (output valid, node_count, input ready);
   modport sink (input valid, node_count, output ready);
endinterface

FILE: rtl/difference_constraint_longest_path.sv
// ----------------------------------------------------------------------------
// difference_constraint_longest_path
// Least marked-position count under interval constraints.
// ----------------------------------------------------------------------------
// Each request item is one constraint and is stored unless the store is
// full; the item with last set then starts a solve and yields one response
// item. The solve runs on a prefix value memory with one read and one write
// port: a range check that reads and checks each stored constraint, a clear
// of positions 0 to n, then up to n+1 relaxation passes (forward and
// backward neighbor sweeps, then the constraints), plus a setup check first
// and a result read last. The request side is not ready during a solve. The
// user writes node_count over the csr channel while idle; not enforced.
`include "assert_macros.svh"

module difference_constraint_longest_path import dcl_pkg::*; #(
   parameter int NODES = 1024,
   parameter int CONSTRAINTS = 1024
) (
   input logic       clock,
   input logic       reset,
   dcl_req_if.sink   req,
   dcl_rsp_if.source rsp,
   dcl_csr_if.sink   csr
);
   localparam int PAW = $clog2(NODES + 1);
   localparam int CAW = (CONSTRAINTS > 1) ? $clog2(CONSTRAINTS) : 1;

   field_type        node_count_ff, node_count_in;
   cmd_type          cmd;
   stat_type         stat;
   logic [PAW-1:0]   node_idx;
   logic [CAW-1:0]   rule_idx;
   logic [VAL_W-1:0] end_value;
   rule_type         in_rule;

   assign csr.ready     = 1'b1;
   assign node_count_in = csr.valid ? csr.node_count : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign in_rule.range_start = req.range_start;
   assign in_rule.range_end   = req.range_end;
   assign in_rule.min_count   = req.min_count;

   dcl_ctrl #(.NODES(NODES), .CONSTRAINTS(CONSTRAINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_last   (req.last),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_total  (rsp.minimum_total),
      .rsp_status (rsp.status),
      .node_count (node_count_ff),
      .cmd        (cmd),
      .node_idx   (node_idx),
      .rule_idx   (rule_idx),
      .stat       (stat),
      .end_value  (end_value)
   );

   dcl_dp #(.NODES(NODES), .CONSTRAINTS(CONSTRAINTS)) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .node_idx   (node_idx),
      .rule_idx   (rule_idx),
      .node_count (node_count_ff),
      .in_rule    (in_rule),
      .stat       (stat),
      .end_value  (end_value)
   );

   `ASSERT_NEXT(a_last_stalls, clock, reset, req.valid && req.ready && req.last, !req.ready, "request side open after last item")
   `ASSERT_SAME(a_fail_zero, clock, reset, rsp.valid && (rsp.status != ST_OK), rsp.minimum_total == '0, "nonzero total on failed batch")
   `ASSERT_SAME(a_total_bound, clock, reset, rsp.valid && (rsp.status == ST_OK), rsp.minimum_total <= node_count_ff, "total above node count")
endmodule

FILE: rtl/dcl_ram.sv
// ----------------------------------------------------------------------------
// dcl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/dcl_dp.sv
// ----------------------------------------------------------------------------
// dcl_dp
// Datapath: constraint store, prefix value memory and relaxation compare.
// ----------------------------------------------------------------------------
module dcl_dp import dcl_pkg::*; #(
   parameter int NODES = 1024,
   parameter int CONSTRAINTS = 1024,
   localparam int PAW = $clog2(NODES + 1),
   localparam int CAW = (CONSTRAINTS > 1) ? $clog2(CONSTRAINTS) : 1
) (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [PAW-1:0]   node_idx,
   input  logic [CAW-1:0]   rule_idx,
   input  field_type        node_count,
   input  rule_type         in_rule,
   output stat_type         stat,
   output logic [VAL_W-1:0] end_value
);
   localparam int RULE_W = $bits(rule_type);

   rule_type         rule_rd;
   logic [RULE_W-1:0] rule_rd_bits;
   rule_type         lat_ff, lat_in;
   logic [VAL_W-1:0] src_ff, src_in;
   logic [VAL_W-1:0] carry_ff, carry_in;
   logic [VAL_W-1:0] node_rd, cand, new_val, n_ext;
   logic             raise, p_wr_en, p_rd_en;
   logic [PAW-1:0]   p_wr_addr, p_rd_addr;
   logic [VAL_W-1:0] p_wr_data;
   field_type        start_m1;

   dcl_ram #(.WIDTH(RULE_W), .DEPTH(CONSTRAINTS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.op == OP_STORE),
      .wr_addr (rule_idx),
      .wr_data (in_rule),
      .rd_en   (cmd.op == OP_RD_RULE),
      .rd_addr (rule_idx),
      .rd_data (rule_rd_bits)
   );
   assign rule_rd = rule_type'(rule_rd_bits);

   dcl_ram #(.WIDTH(VAL_W), .DEPTH(NODES + 1)) u_prefix (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_en   (p_rd_en),
      .rd_addr (p_rd_addr),
      .rd_data (node_rd)
   );

   assign n_ext    = VAL_W'(node_count);
   assign start_m1 = rule_rd.range_start - 1'b1;

   always_comb begin
      cand  = carry_ff;
      raise = 1'b0;
      case (cmd.op)
         OP_FWD: begin
            cand  = carry_ff;
            raise = cand > node_rd;
         end
         OP_BWD: begin
            cand  = carry_ff - 1'b1;
            raise = (carry_ff != '0) && (cand > node_rd);
         end
         OP_CSTR: begin
            cand  = src_ff + VAL_W'(lat_ff.min_count);
            raise = cand > node_rd;
         end
         default: begin
            cand  = carry_ff;
            raise = 1'b0;
         end
      endcase
      new_val = raise ? cand : node_rd;
   end

   always_comb begin
      p_wr_en   = (cmd.op == OP_CLEAR) || raise;
      p_wr_addr = (cmd.op == OP_CSTR) ? PAW'(lat_ff.range_end) : node_idx;
      p_wr_data = (cmd.op == OP_CLEAR) ? '0 : new_val;
      p_rd_en   = (cmd.op == OP_RD_NODE) || (cmd.op == OP_LAT_RULE) ||
                  (cmd.op == OP_LAT_SRC);
      case (cmd.op)
         OP_LAT_RULE: p_rd_addr = PAW'(start_m1);
         OP_LAT_SRC:  p_rd_addr = PAW'(lat_ff.range_end);
         default:     p_rd_addr = node_idx;
      endcase
   end

   always_comb begin
      lat_in   = (cmd.op == OP_LAT_RULE) ? rule_rd : lat_ff;
      src_in   = (cmd.op == OP_LAT_SRC) ? node_rd : src_ff;
      carry_in = carry_ff;
      if (cmd.op == OP_CARRY0) begin
         carry_in = '0;
      end else if ((cmd.op == OP_FWD) || (cmd.op == OP_BWD)) begin
         carry_in = new_val;
      end
   end

   always_ff @(posedge clock) begin
      lat_ff   <= lat_in;
      src_ff   <= src_in;
      carry_ff <= carry_in;
   end

   assign stat.bad_range = (rule_rd.range_start == '0) ||
                           (rule_rd.range_end > node_count) ||
                           (rule_rd.range_start > rule_rd.range_end);
   assign stat.raise     = raise;
   assign stat.over_n    = raise && (cand > n_ext);
   assign end_value      = node_rd;
endmodule

FILE: rtl/dcl_ctrl.sv
// ----------------------------------------------------------------------------
// dcl_ctrl
// Controller: batch loading, range check, relaxation passes and result.
// ----------------------------------------------------------------------------
module dcl_ctrl import dcl_pkg::*; #(
   parameter int NODES = 1024,
   parameter int CONSTRAINTS = 1024,
   localparam int PAW = $clog2(NODES + 1),
   localparam int CAW = (CONSTRAINTS > 1) ? $clog2(CONSTRAINTS) : 1,
   localparam int TW = $clog2(CONSTRAINTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output field_type           rsp_total,
   output logic [STATUS_W-1:0] rsp_status,
   input  field_type           node_count,
   output cmd_type             cmd,
   output logic [PAW-1:0]      node_idx,
   output logic [CAW-1:0]      rule_idx,
   input  stat_type            stat,
   input  logic [VAL_W-1:0]    end_value
);
   localparam logic [4:0] S_IDLE = 5'd0, S_PRECHK = 5'd1, S_RCHK_RD = 5'd2,
      S_RCHK_EV = 5'd3, S_CLR = 5'd4, S_PASS_START = 5'd5, S_FW_RD = 5'd6,
      S_FW_WR = 5'd7, S_BW_RD = 5'd8, S_BW_WR = 5'd9, S_CS_RD = 5'd10,
      S_CS_LAT = 5'd11, S_CS_SRC = 5'd12, S_CS_UPD = 5'd13, S_PASS_END = 5'd14,
      S_RES_RD = 5'd15, S_RES = 5'd16, S_FIN = 5'd17;

   logic [4:0]          state_ff, state_in;
   logic [TW-1:0]       total_ff, total_in;
   logic                err_ff, err_in;
   logic [CAW-1:0]      k_ff, k_in;
   logic [PAW-1:0]      i_ff, i_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                moved_ff, moved_in;
   field_type           res_total_ff, res_total_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   field_type           rsp_total_ff, rsp_total_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                accept, k_last, full;
   logic [PAW-1:0]      n_idx;

   assign accept = req_valid && req_ready;
   assign k_last = (TW'(k_ff) + TW'(1)) == total_ff;
   assign full   = total_ff == TW'(CONSTRAINTS);
   assign n_idx  = PAW'(node_count);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      err_in        = err_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      pass_in       = pass_ff;
      moved_in      = moved_ff;
      res_total_in  = res_total_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      cmd.op        = OP_NOP;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (full) begin
                  err_in = 1'b1;
               end else begin
                  cmd.op   = OP_STORE;
                  total_in = total_ff + 1'b1;
               end
               if (req_last) begin
                  state_in = S_PRECHK;
               end
            end
         end
         S_PRECHK: begin
            k_in = '0;
            i_in = '0;
            res_total_in = '0;
            if (err_ff || (node_count == '0) || (int'(node_count) > NODES)) begin
               res_status_in = ST_BAD;
               state_in      = S_FIN;
            end else if (total_ff == '0) begin
               state_in = S_CLR;
            end else begin
               state_in = S_RCHK_RD;
            end
         end
         S_RCHK_RD: begin
            cmd.op   = OP_RD_RULE;
            state_in = S_RCHK_EV;
         end
         S_RCHK_EV: begin
            if (stat.bad_range) begin
               res_status_in = ST_BAD;
               state_in      = S_FIN;
            end else if (k_last) begin
               state_in = S_CLR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_RCHK_RD;
            end
         end
         S_CLR: begin
            cmd.op = OP_CLEAR;
            i_in   = i_ff + 1'b1;
            if (i_ff == n_idx) begin
               pass_in  = PASS_W'(1);
               state_in = S_PASS_START;
            end
         end
         S_PASS_START: begin
            cmd.op   = OP_CARRY0;
            moved_in = 1'b0;
            i_in     = PAW'(1);
            state_in = S_FW_RD;
         end
         S_FW_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_FW_WR;
         end
         S_FW_WR: begin
            cmd.op = OP_FWD;
            if (stat.raise) begin
               moved_in = 1'b1;
            end
            if (stat.over_n) begin
               res_status_in = ST_INFEASIBLE;
               state_in      = S_FIN;
            end else if (i_ff == n_idx) begin
               i_in     = i_ff - 1'b1;
               state_in = S_BW_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_FW_RD;
            end
         end
         S_BW_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_BW_WR;
         end
         S_BW_WR: begin
            cmd.op = OP_BWD;
            k_in   = '0;
            if (stat.raise) begin
               moved_in = 1'b1;
            end
            if ((stat.raise && (i_ff == '0)) || stat.over_n) begin
               res_status_in = ST_INFEASIBLE;
               state_in      = S_FIN;
            end else if (i_ff == '0) begin
               state_in = (total_ff == '0) ? S_PASS_END : S_CS_RD;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = S_BW_RD;
            end
         end
         S_CS_RD: begin
            cmd.op   = OP_RD_RULE;
            state_in = S_CS_LAT;
         end
         S_CS_LAT: begin
            cmd.op   = OP_LAT_RULE;
            state_in = S_CS_SRC;
         end
         S_CS_SRC: begin
            cmd.op   = OP_LAT_SRC;
            state_in = S_CS_UPD;
         end
         S_CS_UPD: begin
            cmd.op = OP_CSTR;
            if (stat.raise) begin
               moved_in = 1'b1;
            end
            if (stat.over_n) begin
               res_status_in = ST_INFEASIBLE;
               state_in      = S_FIN;
            end else if (k_last) begin
               state_in = S_PASS_END;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_CS_RD;
            end
         end
         S_PASS_END: begin
            if (!moved_ff) begin
               i_in     = n_idx;
               state_in = S_RES_RD;
            end else if (pass_ff == (PASS_W'(node_count) + PASS_W'(1))) begin
               res_status_in = ST_INFEASIBLE;
               state_in      = S_FIN;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = S_PASS_START;
            end
         end
         S_RES_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_RES;
         end
         S_RES: begin
            res_total_in  = FIELD_W'(end_value);
            res_status_in = ST_OK;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = (res_status_ff == ST_OK) ? res_total_ff : '0;
               rsp_status_in = res_status_ff;
               total_in      = '0;
               err_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      i_ff          <= i_in;
      pass_ff       <= pass_in;
      moved_ff      <= moved_in;
      res_total_ff  <= res_total_in;
      res_status_ff <= res_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign node_idx   = i_ff;
   assign rule_idx   = (state_ff == S_IDLE) ? CAW'(total_ff) : k_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_total  = rsp_total_ff;
   assign rsp_status = rsp_status_ff;
endmodule
